// ----- hdl/ffea_pkg.sv -----
`timescale 1ns / 1ps

package ffea_pkg;

  // One free extent as held in a table cell
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] bytes;
  } extent_t;

  // Request sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_GRANT,
    S_INSERT,
    S_FINISH
  } state_e;

  // What the pass unit emits into the tail of the chain
  typedef enum logic [2:0] {
    M_SCAN,
    M_COPY,
    M_SKIP,
    M_PEND,
    M_INS,
    M_NEXTM
  } mode_e;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROP    = 2'd1;
  localparam logic [1:0] ST_EXHAUST = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ARENA_BASE  = 1'b0;
  localparam logic CFG_ARENA_PAGES = 1'b1;

endpackage

// ----- hdl/ffea_cell.sv -----
`timescale 1ns / 1ps

module ffea_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  ffea_pkg::extent_t d_i,
  output ffea_pkg::extent_t q_o
);

  ffea_pkg::extent_t ext_q;

  // Take the neighbor's extent on every shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ext_q <= d_i;
    end
  end

  assign q_o = ext_q;

endmodule

// ----- hdl/first_fit_extent_allocator_core.sv -----
`timescale 1ns / 1ps

// Channel  | Signals                                          | Direction
// ---------+--------------------------------------------------+----------
// request  | in_valid_i/in_ready_o, kind, request, free fields | in
// result   | out_valid_o/out_ready_i, grant, status, counters | out
// config   | cfg_we_i, cfg_index_i, cfg_data_i                | in
//
// Large frees and large allocates make no table pass; a sub-page free makes one insert
// pass, and a sub-page allocate makes a search pass and, if it splits, an insert pass:
// each table pass rotates the whole cell chain once, one cell a cycle.
// Reset clears the counters, the extent count and the sequencer; cells hold
// no reset value. A result waiting on out_ready_i holds the next item only at
// its final step; a new item is taken while the previous result waits.

module first_fit_extent_allocator_core #(
  parameter int TABLE_DEPTH      = 64,
  parameter int PAGE_BYTES       = 4096,
  parameter int HEADER_BYTES     = 8,
  parameter int MIN_EXTENT_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [30:0] request_bytes_i,
  input  logic [31:0] free_address_i,
  input  logic [31:0] free_block_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] user_address_o,
  output logic [31:0] granted_bytes_o,
  output logic [1:0]  status_o,
  output logic [31:0] mapped_pages_o,
  output logic [31:0] unmapped_pages_o,
  output logic [31:0] allocations_o,
  output logic [31:0] frees_o,
  output logic [6:0]  free_entries_o
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int PSH   = $clog2(PAGE_BYTES);
  localparam logic [31:0] PAGE32 = 32'(PAGE_BYTES);
  localparam logic [31:0] HDR32  = 32'(HEADER_BYTES);
  localparam logic [31:0] MIN32  = 32'(MIN_EXTENT_BYTES);

  // Cell chain
  ffea_pkg::extent_t cell_q [TABLE_DEPTH];
  ffea_pkg::extent_t emit;
  logic              shift;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ffea_pkg::extent_t d_in;
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign d_in = emit;
    end else begin : g_body
      assign d_in = cell_q[g + 1];
    end
    ffea_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .d_i    (d_in),
      .q_o    (cell_q[g])
    );
  end

  // Control and payload registers
  ffea_pkg::state_e  state_q, state_d;
  ffea_pkg::mode_e   mode_q, mode_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [20:0]       npi_q, npi_d;
  logic [31:0]       mapped_q, mapped_d, unmapped_q, unmapped_d;
  logic [31:0]       allocs_q, allocs_d, frees_q, frees_d;
  logic [31:0]       base_q;
  logic [20:0]       pages_q;
  logic              kind_q;
  logic [30:0]       req_q;
  logic [31:0]       faddr_q, fbytes_q;
  logic [31:0]       total_q, total_d;
  logic              found_q, found_d;
  ffea_pkg::extent_t cap_q, cap_d, pend_q, pend_d, ins_q, ins_d;
  logic [31:0]       res_user_q, res_user_d, res_gr_q, res_gr_d;
  logic [1:0]        res_st_q, res_st_d;
  logic              ov_q, ov_d;
  logic [31:0]       o_user_q, o_user_d, o_gr_q, o_gr_d;
  logic [1:0]        o_st_q, o_st_d;
  logic [31:0]       o_map_q, o_map_d, o_unm_q, o_unm_d, o_al_q, o_al_d, o_fr_q, o_fr_d;
  logic [6:0]        o_ent_q, o_ent_d;

  assign in_ready_o = (state_q == ffea_pkg::S_IDLE);

  // Pass helpers
  ffea_pkg::extent_t c0, c1;
  logic [CNT_W-1:0]  pos_ext;
  logic              v0, v1, full;
  assign c0      = cell_q[0];
  assign c1      = cell_q[1];
  assign pos_ext = CNT_W'(pos_q);
  assign v0      = pos_ext < cnt_q;
  assign v1      = (pos_ext + CNT_W'(1)) < cnt_q;
  assign full    = cnt_q >= CNT_W'(TABLE_DEPTH);

  logic        adj_prev, adj_next, head_case, prev_case, pass_end;
  logic [31:0] avail, pages_big, bstart, bbytes, diff;
  logic [32:0] unm_sum;
  assign adj_prev  = ({1'b0, c0.start} + {1'b0, c0.bytes}) == {1'b0, ins_q.start};
  assign head_case = (pos_q == '0) && (!v0 || (c0.start > ins_q.start));
  assign prev_case = v0 && (c0.start <= ins_q.start) && (!v1 || (c1.start > ins_q.start));
  assign pass_end  = (pos_q == IDX_W'(TABLE_DEPTH - 1));
  assign avail     = (pages_q > npi_q) ? 32'(pages_q - npi_q) : 32'd0;
  assign pages_big = (total_q + PAGE32 - 32'd1) >> PSH;
  assign unm_sum   = ({1'b0, fbytes_q} + {1'b0, PAGE32} - 33'd1) >> PSH;

  always_comb begin
    adj_next = 1'b0;
    if (head_case) begin
      adj_next = v0 && (({1'b0, ins_q.start} + {1'b0, ins_q.bytes}) == {1'b0, c0.start});
    end else begin
      adj_next = v1 && (({1'b0, ins_q.start} + {1'b0, ins_q.bytes}) == {1'b0, c1.start});
    end
  end

  // Grant source: table hit or a fresh page
  assign bstart = found_q ? cap_q.start : (base_q + (32'(npi_q) << PSH));
  assign bbytes = found_q ? cap_q.bytes : PAGE32;
  assign diff   = bbytes - total_q;

  // Next state and datapath
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    npi_d      = npi_q;
    mapped_d   = mapped_q;
    unmapped_d = unmapped_q;
    allocs_d   = allocs_q;
    frees_d    = frees_q;
    total_d    = total_q;
    found_d    = found_q;
    cap_d      = cap_q;
    pend_d     = pend_q;
    ins_d      = ins_q;
    res_user_d = res_user_q;
    res_gr_d   = res_gr_q;
    res_st_d   = res_st_q;
    ov_d       = ov_q && !out_ready_i;
    o_user_d   = o_user_q;
    o_gr_d     = o_gr_q;
    o_st_d     = o_st_q;
    o_map_d    = o_map_q;
    o_unm_d    = o_unm_q;
    o_al_d     = o_al_q;
    o_fr_d     = o_fr_q;
    o_ent_d    = o_ent_q;
    shift      = 1'b0;
    emit       = c0;

    case (state_q)
      ffea_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ffea_pkg::S_DECODE;
        end
      end

      ffea_pkg::S_DECODE: begin
        res_user_d = 32'd0;
        res_gr_d   = 32'd0;
        res_st_d   = ffea_pkg::ST_OK;
        mode_d     = ffea_pkg::M_SCAN;
        pos_d      = '0;
        found_d    = 1'b0;
        if (!kind_q) begin
          allocs_d = allocs_q + 32'd1;
          total_d  = {1'b0, req_q} + HDR32;
          if (({1'b0, req_q} + HDR32) < PAGE32) begin
            state_d = ffea_pkg::S_SEARCH;
          end else begin
            state_d = ffea_pkg::S_GRANT;
          end
        end else begin
          frees_d     = frees_q + 32'd1;
          ins_d.start = faddr_q - HDR32;
          ins_d.bytes = fbytes_q;
          if (fbytes_q < PAGE32) begin
            state_d = ffea_pkg::S_INSERT;
          end else begin
            unmapped_d = unmapped_q + unm_sum[31:0];
            state_d    = ffea_pkg::S_FINISH;
          end
        end
      end

      // First-fit pass: drop the hit and close the gap
      ffea_pkg::S_SEARCH: begin
        shift = 1'b1;
        case (mode_q)
          ffea_pkg::M_SCAN: begin
            if (v0 && (c0.bytes >= total_q)) begin
              found_d = 1'b1;
              cap_d   = c0;
              emit    = c1;
              cnt_d   = cnt_q - CNT_W'(1);
              mode_d  = ffea_pkg::M_SKIP;
            end
          end
          ffea_pkg::M_SKIP: emit = c1;
          default:          emit = c0;
        endcase
        pos_d = pos_q + IDX_W'(1);
        if (pass_end) begin
          pos_d   = '0;
          state_d = ffea_pkg::S_GRANT;
        end
      end

      ffea_pkg::S_GRANT: begin
        mode_d  = ffea_pkg::M_SCAN;
        state_d = ffea_pkg::S_FINISH;
        if (total_q >= PAGE32) begin
          // Whole pages straight from the bump pointer
          if (pages_big > avail) begin
            res_st_d = ffea_pkg::ST_EXHAUST;
          end else begin
            npi_d      = npi_q + pages_big[20:0];
            mapped_d   = mapped_q + pages_big;
            res_user_d = base_q + (32'(npi_q) << PSH) + HDR32;
            res_gr_d   = pages_big << PSH;
          end
        end else if (!found_q && (avail == 32'd0)) begin
          res_st_d = ffea_pkg::ST_EXHAUST;
        end else begin
          if (!found_q) begin
            npi_d    = npi_q + 21'd1;
            mapped_d = mapped_q + 32'd1;
          end
          res_user_d = bstart + HDR32;
          res_gr_d   = bbytes;
          if ((bbytes > total_q) && (diff >= MIN32)) begin
            ins_d.start = bstart + total_q;
            ins_d.bytes = diff;
            res_gr_d    = total_q;
            state_d     = ffea_pkg::S_INSERT;
          end
        end
      end

      // Sorted insert with merging on both sides
      ffea_pkg::S_INSERT: begin
        shift = 1'b1;
        case (mode_q)
          ffea_pkg::M_SCAN: begin
            if (head_case) begin
              if (adj_next) begin
                emit.start = ins_q.start;
                emit.bytes = ins_q.bytes + c0.bytes;
                mode_d     = ffea_pkg::M_COPY;
              end else if (full) begin
                res_st_d = ffea_pkg::ST_DROP;
                mode_d   = ffea_pkg::M_COPY;
              end else begin
                emit   = ins_q;
                pend_d = c0;
                cnt_d  = cnt_q + CNT_W'(1);
                mode_d = ffea_pkg::M_PEND;
              end
            end else if (prev_case) begin
              if (adj_prev && adj_next) begin
                emit.bytes = c0.bytes + ins_q.bytes + c1.bytes;
                cnt_d      = cnt_q - CNT_W'(1);
                mode_d     = ffea_pkg::M_SKIP;
              end else if (adj_prev) begin
                emit.bytes = c0.bytes + ins_q.bytes;
                mode_d     = ffea_pkg::M_COPY;
              end else if (adj_next) begin
                mode_d = ffea_pkg::M_NEXTM;
              end else if (full) begin
                res_st_d = ffea_pkg::ST_DROP;
                mode_d   = ffea_pkg::M_COPY;
              end else begin
                cnt_d  = cnt_q + CNT_W'(1);
                mode_d = ffea_pkg::M_INS;
              end
            end
          end
          ffea_pkg::M_NEXTM: begin
            emit.start = ins_q.start;
            emit.bytes = ins_q.bytes + c0.bytes;
            mode_d     = ffea_pkg::M_COPY;
          end
          ffea_pkg::M_INS: begin
            emit   = ins_q;
            pend_d = c0;
            mode_d = ffea_pkg::M_PEND;
          end
          ffea_pkg::M_PEND: begin
            emit   = pend_q;
            pend_d = c0;
          end
          ffea_pkg::M_SKIP: emit = c1;
          default:          emit = c0;
        endcase
        pos_d = pos_q + IDX_W'(1);
        if (pass_end) begin
          pos_d   = '0;
          state_d = ffea_pkg::S_FINISH;
        end
      end

      // Load the output register once it is free
      ffea_pkg::S_FINISH: begin
        if (!ov_q || out_ready_i) begin
          ov_d     = 1'b1;
          o_user_d = res_user_q;
          o_gr_d   = res_gr_q;
          o_st_d   = res_st_q;
          o_map_d  = mapped_q;
          o_unm_d  = unmapped_q;
          o_al_d   = allocs_q;
          o_fr_d   = frees_q;
          o_ent_d  = 7'(cnt_q);
          state_d  = ffea_pkg::S_IDLE;
        end
      end

      default: state_d = ffea_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ffea_pkg::S_IDLE;
      mode_q     <= ffea_pkg::M_SCAN;
      pos_q      <= '0;
      cnt_q      <= '0;
      npi_q      <= '0;
      mapped_q   <= '0;
      unmapped_q <= '0;
      allocs_q   <= '0;
      frees_q    <= '0;
      ov_q       <= 1'b0;
      base_q     <= '0;
      pages_q    <= 21'h100000;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      npi_q      <= npi_d;
      mapped_q   <= mapped_d;
      unmapped_q <= unmapped_d;
      allocs_q   <= allocs_d;
      frees_q    <= frees_d;
      ov_q       <= ov_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          ffea_pkg::CFG_ARENA_BASE:  base_q  <= cfg_data_i;
          ffea_pkg::CFG_ARENA_PAGES: pages_q <= cfg_data_i[20:0];
          default: ;
        endcase
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q   <= kind_i;
      req_q    <= request_bytes_i;
      faddr_q  <= free_address_i;
      fbytes_q <= free_block_bytes_i;
    end
    total_q    <= total_d;
    found_q    <= found_d;
    cap_q      <= cap_d;
    pend_q     <= pend_d;
    ins_q      <= ins_d;
    res_user_q <= res_user_d;
    res_gr_q   <= res_gr_d;
    res_st_q   <= res_st_d;
    o_user_q   <= o_user_d;
    o_gr_q     <= o_gr_d;
    o_st_q     <= o_st_d;
    o_map_q    <= o_map_d;
    o_unm_q    <= o_unm_d;
    o_al_q     <= o_al_d;
    o_fr_q     <= o_fr_d;
    o_ent_q    <= o_ent_d;
  end

  assign out_valid_o      = ov_q;
  assign user_address_o   = o_user_q;
  assign granted_bytes_o  = o_gr_q;
  assign status_o         = o_st_q;
  assign mapped_pages_o   = o_map_q;
  assign unmapped_pages_o = o_unm_q;
  assign allocations_o    = o_al_q;
  assign frees_o          = o_fr_q;
  assign free_entries_o   = o_ent_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("extent count above table depth");

  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ffea_pkg::S_SEARCH && state_q != ffea_pkg::S_INSERT) |-> pos_q == '0)
    else $error("pass position not parked outside a pass");

  a_exhaust_nogrant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_st_q == ffea_pkg::ST_EXHAUST) |-> (o_gr_q == 32'd0 && o_user_q == 32'd0))
    else $error("grant reported with exhausted arena");

endmodule

// ----- sim/first_fit_extent_allocator_core_test.sv -----
`timescale 1ns / 1ps

module first_fit_extent_allocator_core_test;

  localparam int  DEPTH     = 64;
  localparam int  PAGE      = 4096;
  localparam int  HDR       = 8;
  localparam int  MIN_SPLIT = 16;
  localparam int  LIMIT     = 2000000;
  localparam int  DRAIN     = 200;
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic [31:0] user;
    logic [31:0] granted;
    logic [1:0]  status;
    logic [31:0] mapped;
    logic [31:0] unmapped;
    logic [31:0] allocs;
    logic [31:0] frees;
    logic [6:0]  entries;
  } grant_t;

  typedef struct {
    bit          is_cfg;
    logic        cfg_idx;
    logic        kind;
    logic [30:0] req;
    logic [31:0] faddr;
    logic [31:0] fbytes;
    bit          chk;
    logic [31:0] user;
    logic [31:0] granted;
    logic [1:0]  status;
  } row_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] bytes;
  } block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [30:0] request_bytes_i = '0;
  logic [31:0] free_address_i = '0;
  logic [31:0] free_block_bytes_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] user_address_o;
  logic [31:0] granted_bytes_o;
  logic [1:0]  status_o;
  logic [31:0] mapped_pages_o;
  logic [31:0] unmapped_pages_o;
  logic [31:0] allocations_o;
  logic [31:0] frees_o;
  logic [6:0]  free_entries_o;

  first_fit_extent_allocator_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .kind_i, .request_bytes_i, .free_address_i,
    .free_block_bytes_i, .out_valid_o, .out_ready_i, .user_address_o,
    .granted_bytes_o, .status_o, .mapped_pages_o, .unmapped_pages_o,
    .allocations_o, .frees_o, .free_entries_o
  );

  // Shadow allocator state
  logic [31:0] sh_start [DEPTH];
  logic [31:0] sh_bytes [DEPTH];
  int          sh_count;
  logic [31:0] sh_next_page;
  logic [31:0] sh_mapped, sh_unmapped, sh_allocs, sh_frees;
  logic [31:0] sh_base;
  logic [31:0] sh_pages;

  grant_t pending_grants[$];
  block_t live_blocks[$];
  int     fails = 0;
  int     cycles = 0;
  int     burst_left = 0;
  int     stall_mode = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Drop the extent at position p, closing the gap
  function automatic void drop_extent(int p);
    for (int i = p; i + 1 < sh_count; i++) begin
      sh_start[i] = sh_start[i + 1];
      sh_bytes[i] = sh_bytes[i + 1];
    end
    sh_count--;
  endfunction

  // Insert in address order with coalescing; return 0 when a new entry is needed and the table is full
  function automatic bit place_extent(logic [31:0] s, logic [31:0] b);
    int p = 0;
    bit adj_lo = 0;
    bit adj_hi = 0;
    while (p < sh_count && sh_start[p] <= s) p++;
    if (p > 0) adj_lo = (33'(sh_start[p-1]) + 33'(sh_bytes[p-1])) == 33'(s);
    if (p < sh_count) adj_hi = (33'(s) + 33'(b)) == 33'(sh_start[p]);
    if (adj_lo && adj_hi) begin
      sh_bytes[p-1] = sh_bytes[p-1] + b + sh_bytes[p];
      drop_extent(p);
    end else if (adj_lo) begin
      sh_bytes[p-1] = sh_bytes[p-1] + b;
    end else if (adj_hi) begin
      sh_start[p] = s;
      sh_bytes[p] = b + sh_bytes[p];
    end else begin
      if (sh_count >= DEPTH) return 0;
      for (int i = sh_count; i > p; i--) begin
        sh_start[i] = sh_start[i-1];
        sh_bytes[i] = sh_bytes[i-1];
      end
      sh_start[p] = s;
      sh_bytes[p] = b;
      sh_count++;
    end
    return 1;
  endfunction

  // Compute the grant for one accepted request and advance the shadow state
  function automatic grant_t serve_request(logic kind, logic [30:0] req,
                                           logic [31:0] faddr, logic [31:0] fbytes);
    grant_t g = '0;
    logic [31:0] total = 32'(req) + HDR;
    logic [31:0] avail = (sh_pages > sh_next_page) ? sh_pages - sh_next_page : 0;
    logic [31:0] bstart = '0;
    logic [31:0] bbytes = '0;
    logic [63:0] npages;
    bit found = 0;
    g.status = ffea_pkg::ST_OK;
    if (kind == KIND_ALLOC) begin
      sh_allocs++;
      if (total < PAGE) begin
        for (int i = 0; i < sh_count; i++) begin
          if (sh_bytes[i] >= total) begin
            found = 1;
            bstart = sh_start[i];
            bbytes = sh_bytes[i];
            drop_extent(i);
            break;
          end
        end
        if (!found) begin
          if (avail == 0) begin
            g.status = ffea_pkg::ST_EXHAUST;
          end else begin
            bstart = sh_base + sh_next_page * PAGE;
            bbytes = PAGE;
            sh_next_page++;
            sh_mapped++;
            found = 1;
          end
        end
        if (found) begin
          if (bbytes > total && bbytes - total >= MIN_SPLIT) begin
            if (!place_extent(bstart + total, bbytes - total)) g.status = ffea_pkg::ST_DROP;
            bbytes = total;
          end
          g.user = bstart + HDR;
          g.granted = bbytes;
        end
      end else begin
        npages = (64'(total) + PAGE - 1) / PAGE;
        if (npages > 64'(avail)) begin
          g.status = ffea_pkg::ST_EXHAUST;
        end else begin
          bstart = sh_base + sh_next_page * PAGE;
          sh_next_page += 32'(npages);
          sh_mapped += 32'(npages);
          g.user = bstart + HDR;
          g.granted = 32'(npages * PAGE);
        end
      end
    end else begin
      sh_frees++;
      if (fbytes < PAGE) begin
        if (!place_extent(faddr - HDR, fbytes)) g.status = ffea_pkg::ST_DROP;
      end else begin
        sh_unmapped += 32'((64'(fbytes) + PAGE - 1) / PAGE);
      end
    end
    g.mapped = sh_mapped;
    g.unmapped = sh_unmapped;
    g.allocs = sh_allocs;
    g.frees = sh_frees;
    g.entries = 7'(sh_count);
    return g;
  endfunction

  // Hold valid until the item is taken, then record its expected grant
  task automatic send_request(logic kind, logic [30:0] req, logic [31:0] faddr,
                              logic [31:0] fbytes, bit chk, logic [31:0] user,
                              logic [31:0] granted, logic [1:0] status);
    grant_t g;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    kind_i <= kind;
    request_bytes_i <= req;
    free_address_i <= faddr;
    free_block_bytes_i <= fbytes;
    do @(posedge clk_i); while (!in_ready_o);
    g = serve_request(kind, req, faddr, fbytes);
    if (chk) begin
      g.user = user;
      g.granted = granted;
      g.status = status;
    end
    if (kind == KIND_ALLOC && g.granted != 0) live_blocks.push_back('{g.user, g.granted});
    pending_grants.push_back(g);
  endtask

  // Let every expected result arrive and the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    if (idx == ffea_pkg::CFG_ARENA_BASE) sh_base = data;
    else sh_pages = data & 32'h1FFFFF;
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random request: mostly allocs of small sizes and frees of live blocks
  task automatic random_request();
    int pick;
    int sel = $urandom_range(0, 99);
    logic [30:0] req;
    logic [31:0] fb;
    block_t blk;
    if (sel < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) req = 31'($urandom_range(0, 300));
      else if (pick < 93) req = 31'($urandom_range(301, 4087));
      else if (pick < 99) req = 31'($urandom_range(4088, 40000));
      else req = 31'($urandom_range(40001, 1 << 30));
      send_request(KIND_ALLOC, req, $urandom, $urandom, 0, 0, 0, ffea_pkg::ST_OK);
    end else if (sel < 88 && live_blocks.size() != 0) begin
      pick = $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[pick];
      live_blocks.delete(pick);
      send_request(KIND_FREE, 31'($urandom), blk.addr, blk.bytes, 0, 0, 0, ffea_pkg::ST_OK);
    end else begin
      pick = $urandom_range(0, 9);
      fb = (pick == 0) ? $urandom : (pick == 1) ? 32'd0 : $urandom_range(1, 4095);
      send_request(KIND_FREE, 31'($urandom), $urandom, fb, 0, 0, 0, ffea_pkg::ST_OK);
    end
  endtask

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("first_fit_extent_allocator_core regression: fail");
      $finish;
    end
  end

  // Receiver: check each taken result, then pick the next stall
  always @(posedge clk_i) begin
    grant_t act, want;
    if (out_valid_o && out_ready_i) begin
      act = '{user_address_o, granted_bytes_o, status_o, mapped_pages_o,
              unmapped_pages_o, allocations_o, frees_o, free_entries_o};
      if (pending_grants.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, act);
        fails++;
      end else begin
        want = pending_grants.pop_front();
        if (act !== want) begin
          fails++;
          if (act.user !== want.user)
            $display("%0t: user_address exp %h got %h", $time, want.user, act.user);
          if (act.granted !== want.granted)
            $display("%0t: granted_bytes exp %h got %h", $time, want.granted, act.granted);
          if (act.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, act.status);
          if (act.mapped !== want.mapped)
            $display("%0t: mapped_pages exp %0d got %0d", $time, want.mapped, act.mapped);
          if (act.unmapped !== want.unmapped)
            $display("%0t: unmapped_pages exp %0d got %0d", $time, want.unmapped,
                     act.unmapped);
          if (act.allocs !== want.allocs)
            $display("%0t: allocations exp %0d got %0d", $time, want.allocs, act.allocs);
          if (act.frees !== want.frees)
            $display("%0t: frees exp %0d got %0d", $time, want.frees, act.frees);
          if (act.entries !== want.entries)
            $display("%0t: free_entries exp %0d got %0d", $time, want.entries, act.entries);
        end
      end
    end
    if (cycles % 150 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= (cycles % 16) < 3;
    endcase
  end

  initial begin
    row_t rows[$];
    logic [31:0] rnd_addr;
    sh_count = 0;
    sh_next_page = 0;
    sh_mapped = 0;
    sh_unmapped = 0;
    sh_allocs = 0;
    sh_frees = 0;
    sh_base = 0;
    sh_pages = 1048576;
    rnd_addr = $urandom;

    // Directed rows: allocs at the size extremes, odd frees, exhaustion
    rows.push_back('{0, 0, KIND_ALLOC, 31'd0, 0, 0, 1, 32'd8, 32'd8, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_ALLOC, 31'd4088, 0, 0, 1, 32'd4104, 32'd4096,
                     ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_ALLOC, 31'h40000000, 0, 0, 1, 32'd8200, 32'h40001000,
                     ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_ALLOC, 31'd4087, 0, 0, 1, 32'h40003008, 32'd4096,
                     ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_FREE, 31'h7FFFFFFF, 32'd16, 32'd8, 0, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_FREE, 0, 32'd0, 32'd4095, 0, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_FREE, 0, 32'hFFFFFFFF, 32'd0, 0, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_FREE, 0, rnd_addr, 32'hFFFFFFFF, 1, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_FREE, 0, ~rnd_addr, 32'd4096, 1, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_ALLOC, 31'd4080, 0, 0, 0, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_ALLOC, 31'h40000000, 0, 0, 0, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_ALLOC, 31'd100, 0, 0, 0, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{1, ffea_pkg::CFG_ARENA_PAGES, 0, 0, 32'd1, 0, 0, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_ALLOC, 31'h40000000, 0, 0, 1, 0, 0, ffea_pkg::ST_EXHAUST});
    rows.push_back('{0, 0, KIND_ALLOC, 31'd5000, 0, 0, 1, 0, 0, ffea_pkg::ST_EXHAUST});
    rows.push_back('{0, 0, KIND_ALLOC, 31'd4000, 0, 0, 0, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{1, ffea_pkg::CFG_ARENA_BASE, 0, 0, 32'hFFFFF000, 0, 0, 0, 0,
                     ffea_pkg::ST_OK});
    rows.push_back('{1, ffea_pkg::CFG_ARENA_PAGES, 0, 0, 32'd1048576, 0, 0, 0, 0,
                     ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_ALLOC, 31'd4088, 0, 0, 0, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_ALLOC, 31'd3000, 0, 0, 0, 0, 0, ffea_pkg::ST_OK});
    rows.push_back('{0, 0, KIND_FREE, 0, 32'h7FFFFFF8, 32'd24, 0, 0, 0, ffea_pkg::ST_OK});

    // Hold reset, then release
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        write_reg(rows[i].cfg_idx, rows[i].faddr);
        end_writes();
      end else begin
        send_request(rows[i].kind, rows[i].req, rows[i].faddr, rows[i].fbytes,
                     rows[i].chk, rows[i].user, rows[i].granted, rows[i].status);
      end
    end

    // Random phases under different arena settings
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(ffea_pkg::CFG_ARENA_BASE, 32'h10000000);
          write_reg(ffea_pkg::CFG_ARENA_PAGES, 32'd1048576);
        end
        1: begin
          write_reg(ffea_pkg::CFG_ARENA_BASE, 32'hFFFFF000);
          write_reg(ffea_pkg::CFG_ARENA_PAGES, 32'd1);
        end
        2: begin
          write_reg(ffea_pkg::CFG_ARENA_BASE, $urandom & 32'hFFFFF000);
          write_reg(ffea_pkg::CFG_ARENA_PAGES, $urandom_range(1, 1048576));
        end
        default: begin
          write_reg(ffea_pkg::CFG_ARENA_BASE, 32'd0);
          write_reg(ffea_pkg::CFG_ARENA_PAGES, 32'd1048576);
        end
      endcase
      end_writes();
      repeat (345) random_request();
    end

    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fails == 0) begin
      $display("first_fit_extent_allocator_core regression: pass");
    end else begin
      $display("first_fit_extent_allocator_core regression: fail");
    end
    $finish;
  end

endmodule
